// File: sv/integer_to_ascii_formatter_macros.svh
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// concurrent checks clocked on aclk, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTH
`define ITOA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error("itoa check");
`define ITOA_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) else $error("itoa reset check");
`else
`define ITOA_ASSERT(lbl, prop)
`define ITOA_ASSERT_RST(lbl, prop)
`endif

`endif

// File: sv/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// shared types, constants and the digit conversion step of the formatter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    localparam int MAX_CHARS_DEF = 64;

    localparam logic [1:0] MODE_SDEC = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;
    localparam logic [1:0] MODE_UDEC = 2'd2;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] HEX_GAP     = 8'd39;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    localparam int NUM_DIG   = 10;
    localparam int BITS_STEP = 8;

    typedef struct packed {
        logic [31:0] mag;
        logic [39:0] bcd;
        logic        hex;
        logic        sign;
        logic [5:0]  minw;
        logic [5:0]  lim;
    } stage_t;

    typedef struct packed {
        logic [39:0] digits;
        logic        sign;
        logic [5:0]  dw;
        logic [5:0]  nd;
        logic [5:0]  full;
        logic [5:0]  count;
        logic        empty;
    } conv_t;

    // eight double-dabble steps on one byte of the magnitude
    function automatic logic [39:0] dabble(input logic [39:0] bcd_in,
                                           input logic [7:0] bits);
        logic [39:0] b;
        b = bcd_in;
        for (int s = BITS_STEP - 1; s >= 0; s--) begin
            for (int d = 0; d < NUM_DIG; d++) begin
                if (b[d*4 +: 4] >= 4'd5) begin
                    b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
                end
            end
            b = {b[38:0], bits[s]};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: sv/itoa_conv.sv
// ---------------------------------------------------------------------------
// itoa_conv
// six stage conversion pipeline: sign and clamp, four binary to bcd stages,
// length and truncation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_conv #(
    parameter int MAX_CHARS = itoa_pkg::MAX_CHARS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [31:0]   in_value,
    input  wire logic [1:0]    in_mode,
    input  wire logic [5:0]    in_min_digits,
    input  wire logic [6:0]    in_space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output itoa_pkg::conv_t    out_item
);

    localparam logic [6:0] MAX_SP = 7'(MAX_CHARS);
    localparam int NST = 5;

    itoa_pkg::stage_t st_reg  [NST];
    itoa_pkg::stage_t st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic [NST-1:0]   vld_next;
    itoa_pkg::conv_t  cv_reg, cv_next;
    logic             cvv_reg, cvv_next;
    logic             adv;

    logic [6:0]  sp;
    logic        neg;
    logic [5:0]  nd;
    logic [5:0]  dw;
    logic [5:0]  full;
    logic [5:0]  cnt;

    assign adv      = !cvv_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        sp  = (in_space > MAX_SP) ? MAX_SP : in_space;
        neg = (in_mode == itoa_pkg::MODE_SDEC) && in_value[31] && (sp > 7'd1);
        st_next[0].mag  = neg ? (32'd0 - in_value) : in_value;
        st_next[0].bcd  = '0;
        st_next[0].hex  = (in_mode == itoa_pkg::MODE_HEX);
        st_next[0].sign = neg;
        st_next[0].minw = (neg && in_min_digits != 6'd0) ? in_min_digits - 6'd1 : in_min_digits;
        st_next[0].lim  = (sp > 7'd0) ? 6'(sp - 7'd1) : 6'd0;
        vld_next[0]     = in_valid;
        for (int k = 1; k < NST; k++) begin
            st_next[k]     = st_reg[k-1];
            st_next[k].bcd = itoa_pkg::dabble(st_reg[k-1].bcd,
                                              st_reg[k-1].mag[31 - 8*(k-1) -: 8]);
            vld_next[k]    = vld_reg[k-1];
        end
    end

    // digit count, padded width and truncation
    always_comb begin
        cv_next.digits = st_reg[NST-1].hex ? {8'd0, st_reg[NST-1].mag} : st_reg[NST-1].bcd;
        nd = 6'd1;
        for (int d = 1; d < itoa_pkg::NUM_DIG; d++) begin
            if (cv_next.digits[d*4 +: 4] != 4'd0) begin
                nd = 6'(d + 1);
            end
        end
        dw   = (nd > st_reg[NST-1].minw) ? nd : st_reg[NST-1].minw;
        full = dw + {5'd0, st_reg[NST-1].sign};
        cnt  = (st_reg[NST-1].lim < full) ? st_reg[NST-1].lim : full;
        cv_next.sign  = st_reg[NST-1].sign;
        cv_next.dw    = dw;
        cv_next.nd    = nd;
        cv_next.full  = full;
        cv_next.count = cnt;
        cv_next.empty = (cnt == 6'd0);
        cvv_next      = vld_reg[NST-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            cvv_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= vld_next;
            cvv_reg <= cvv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NST; k++) begin
                st_reg[k] <= st_next[k];
            end
            cv_reg <= cv_next;
        end
    end

    assign out_valid = cvv_reg;
    assign out_item  = cv_reg;

endmodule

`default_nettype wire

// File: sv/itoa_emit.sv
// ---------------------------------------------------------------------------
// itoa_emit
// serializes one converted item into characters, one per cycle while out_ready does not stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_emit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire itoa_pkg::conv_t  in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_char,
    output logic                  out_char_valid,
    output logic                  out_last,
    output logic [5:0]            out_len
);

    logic            act_reg, act_next;
    itoa_pkg::conv_t it_reg;
    logic [5:0]      idx_reg, idx_next;
    logic            ov_reg, ov_next;
    logic [7:0]      ch_reg;
    logic            cv_reg;
    logic            lst_reg;
    logic [5:0]      len_reg;

    logic [5:0] ecnt;
    logic       is_last;
    logic       fire;
    logic       done;
    logic       take;
    logic [5:0] j;
    logic [5:0] k;
    logic [3:0] nib;
    logic [7:0] ch;

    assign ecnt    = it_reg.empty ? 6'd1 : it_reg.count;
    assign is_last = (idx_reg == ecnt - 6'd1);
    assign fire    = act_reg && (!ov_reg || out_ready);
    assign done    = fire && is_last;
    assign take    = in_valid && (!act_reg || done);
    assign in_ready = !act_reg || done;

    always_comb begin
        j   = idx_reg - {5'd0, it_reg.sign};
        k   = it_reg.dw - 6'd1 - j;
        nib = it_reg.digits[k[3:0]*4 +: 4];
        ch  = itoa_pkg::ASCII_ZERO + {4'd0, nib};
        if (ch > itoa_pkg::ASCII_NINE) begin
            ch = ch + itoa_pkg::HEX_GAP;
        end
        if (it_reg.empty) begin
            ch = 8'd0;
        end else if (it_reg.sign && idx_reg == 6'd0) begin
            ch = itoa_pkg::ASCII_MINUS;
        end else if (j < it_reg.dw - it_reg.nd) begin
            ch = itoa_pkg::ASCII_ZERO;
        end
    end

    always_comb begin
        act_next = act_reg;
        idx_next = idx_reg;
        if (take) begin
            act_next = 1'b1;
            idx_next = 6'd0;
        end else if (done) begin
            act_next = 1'b0;
        end else if (fire) begin
            idx_next = idx_reg + 6'd1;
        end
        ov_next = fire ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (take) begin
            it_reg <= in_item;
        end
        if (fire) begin
            ch_reg  <= ch;
            cv_reg  <= !it_reg.empty;
            lst_reg <= is_last;
            len_reg <= it_reg.full;
        end
    end

    assign out_valid      = ov_reg;
    assign out_char       = ch_reg;
    assign out_char_valid = cv_reg;
    assign out_last       = lst_reg;
    assign out_len        = len_reg;

endmodule

`default_nettype wire

// File: sv/integer_to_ascii_formatter.sv
// an item passes the conversion pipeline and then the emitter's item and character registers
// throughput: one character per cycle while m_tready does not stall the output
// the pipeline takes a new item each cycle unless stalled; the character emitter sets the rate
// reset: synchronous active-low aresetn clears all valid bits, no item or character survives
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// formats a 32-bit value as signed decimal, lower-case hex or unsigned decimal
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
    parameter int MAX_CHARS = itoa_pkg::MAX_CHARS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // value[31:0] mode[33:32] min_digits[39:34] space[46:40]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // char_out[7:0] full_length[13:8]
    output logic             m_tuser,   // char_valid
    output logic             m_tlast
);

    logic            cv_valid;
    logic            cv_ready;
    itoa_pkg::conv_t cv_item;
    logic [7:0]      ch;
    logic [5:0]      len;

    itoa_conv #(.MAX_CHARS(MAX_CHARS)) u_conv (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_value      (s_tdata[31:0]),
        .in_mode       (s_tdata[33:32]),
        .in_min_digits (s_tdata[39:34]),
        .in_space      (s_tdata[46:40]),
        .out_valid     (cv_valid),
        .out_ready     (cv_ready),
        .out_item      (cv_item)
    );

    itoa_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (cv_valid),
        .in_ready       (cv_ready),
        .in_item        (cv_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_char       (ch),
        .out_char_valid (m_tuser),
        .out_last       (m_tlast),
        .out_len        (len)
    );

    assign m_tdata = {2'b00, len, ch};

    `ITOA_ASSERT(a_empty_is_last, m_tvalid && !m_tuser |-> m_tlast)
    `ITOA_ASSERT(a_empty_no_char, m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    `ITOA_ASSERT_RST(a_reset_clears, !aresetn |=> !m_tvalid)

endmodule

`default_nettype wire

// File: dv/integer_to_ascii_formatter_tb.sv
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// drives formatting requests over the input stream and checks every emitted
// character, its valid flag, last marker and logical length against a
// built-in predictor of the formatter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       last;
        logic [5:0] full_len;
    } char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    logic [47:0] pending_q[$];
    char_t       chars_q[$];
    int          mismatches = 0;
    int          fails = 0;
    longint      cycles = 0;
    int          hold_cycles = 0;
    bit          hold_start = 1'b0;
    bit          hold_taken = 1'b0;
    bit          calm = 1'b0;
    bit          src_pause = 1'b0;

    integer_to_ascii_formatter i_dut (.*);

    always #6 aclk = ~aclk;

    // predict the characters of one item
    function automatic void format_item(input logic [47:0] item);
        logic [31:0] v, mag;
        logic [1:0]  mode;
        int          minw, space, nd, dw, full, count, base, d;
        logic [7:0]  digs[12];
        logic [7:0]  text[72];
        char_t       c;
        v     = item[31:0];
        mode  = item[33:32];
        minw  = item[39:34];
        space = item[46:40];
        base  = (mode == itoa_pkg::MODE_HEX) ? 16 : 10;
        nd    = 0;
        full  = 0;
        mag   = v;
        if (space > itoa_pkg::MAX_CHARS_DEF) space = itoa_pkg::MAX_CHARS_DEF;
        if (mode == itoa_pkg::MODE_SDEC && v[31] && space > 1) begin
            text[full++] = itoa_pkg::ASCII_MINUS;
            mag = -v;
            minw = minw - 1;
        end
        do begin
            d = mag % base;
            digs[nd] = itoa_pkg::ASCII_ZERO + d;
            if (digs[nd] > itoa_pkg::ASCII_NINE)
                digs[nd] = digs[nd] + itoa_pkg::HEX_GAP;
            nd++;
            mag = mag / base;
        end while (mag != 0);
        dw = (nd > minw) ? nd : minw;
        for (int i = 0; i < dw - nd; i++) text[full++] = itoa_pkg::ASCII_ZERO;
        for (int i = nd - 1; i >= 0; i--) text[full++] = digs[i];
        count = (space > 0) ? space - 1 : 0;
        if (count > full) count = full;
        if (count == 0) begin
            c = '{8'd0, 1'b0, 1'b1, full[5:0]};
            chars_q.push_back(c);
        end
        for (int i = 0; i < count; i++) begin
            c = '{text[i], 1'b1, i == count - 1, full[5:0]};
            chars_q.push_back(c);
        end
    endfunction

    function automatic logic [47:0] pack_item(logic [31:0] v, logic [1:0] mode,
                                              logic [5:0] minw, logic [6:0] space);
        return {1'b0, space, minw, mode, v};
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return 32'hffff_ffff - $urandom_range(0, 20);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return $urandom_range(0, 99999);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [6:0] rand_space();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 127);
        if ($urandom_range(0, 19) == 0) return $urandom_range(0, 1);
        return $urandom_range(2, 16);
    endfunction

    // driver
    always @(negedge aclk) begin
        if (s_tvalid && !s_tready) begin
        end else if (pending_q.size() > 0 && !src_pause && aresetn
                     && (calm || $urandom_range(0, 99) >= 34)) begin
            s_tdata  <= pending_q.pop_front();
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (hold_start && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_cycles <= 300;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 34;
        end
    end

    // monitor
    always @(posedge aclk) begin
        char_t got, want;
        cycles <= cycles + 1;
        if (aresetn && s_tvalid && s_tready) format_item(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tuser, m_tlast, m_tdata[13:8]};
            if (chars_q.size() == 0) begin
                fails++;
                if (mismatches++ < 10) $display("unexpected item %h", got);
            end else begin
                want = chars_q.pop_front();
                if (got !== want) begin
                    fails++;
                    if (mismatches++ < 10)
                        $display({"mismatch exp ch=%h v=%b l=%b len=%0d ",
                                  "got ch=%h v=%b l=%b len=%0d"},
                                 want.ch, want.ch_valid, want.last, want.full_len,
                                 got.ch, got.ch_valid, got.last, got.full_len);
                end
            end
        end
        if (cycles > 400000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        logic [1:0] mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed items
        pending_q.push_back(pack_item(32'd0, itoa_pkg::MODE_SDEC, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'hffff_ffff, itoa_pkg::MODE_SDEC, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'h8000_0000, itoa_pkg::MODE_SDEC, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'h7fff_ffff, itoa_pkg::MODE_SDEC, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'hffff_ffff, itoa_pkg::MODE_HEX, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'hdead_beef, itoa_pkg::MODE_HEX, 6'd12, 7'd20));
        pending_q.push_back(pack_item(32'hffff_ffff, itoa_pkg::MODE_UDEC, 6'd0, 7'd64));
        pending_q.push_back(pack_item(32'd1234, 2'd3, 6'd6, 7'd64));
        pending_q.push_back(pack_item(32'd5, itoa_pkg::MODE_UDEC, 6'd63, 7'd127));
        pending_q.push_back(pack_item(32'hffff_fff0, itoa_pkg::MODE_SDEC, 6'd63, 7'd100));
        pending_q.push_back(pack_item(32'hffff_fff0, itoa_pkg::MODE_SDEC, 6'd0, 7'd1));
        pending_q.push_back(pack_item(32'hffff_fff0, itoa_pkg::MODE_SDEC, 6'd8, 7'd0));
        pending_q.push_back(pack_item(32'd42, itoa_pkg::MODE_UDEC, 6'd0, 7'd1));
        pending_q.push_back(pack_item(32'hffff_fff0, itoa_pkg::MODE_SDEC, 6'd5, 7'd2));
        pending_q.push_back(pack_item(32'd987654321, itoa_pkg::MODE_UDEC, 6'd3, 7'd5));
        pending_q.push_back(pack_item(32'hffff_ff85, itoa_pkg::MODE_SDEC, 6'd1, 7'd64));
        pending_q.push_back(pack_item(32'h0000_00ab, itoa_pkg::MODE_HEX, 6'd1, 7'd64));
        // random items, with a long receiver hold-off part way
        for (int i = 0; i < 360; i++) begin
            mode = $urandom_range(0, 9) == 0 ? 2'd3 : $urandom_range(0, 2);
            pending_q.push_back(pack_item(rand_value(), mode,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12),
                rand_space()));
            if (i == 100) begin
                while (pending_q.size() > 0) @(posedge aclk);
                hold_start <= 1'b1;
                for (int k = 0; k < 40; k++)
                    pending_q.push_back(pack_item($urandom, $urandom_range(0, 2),
                                                  $urandom_range(0, 8), 7'd12));
                @(posedge aclk);
                while (!hold_taken || hold_cycles > 0) @(posedge aclk);
                src_pause <= 1'b1;
                @(posedge aclk);
                while (s_tvalid || chars_q.size() > 0) @(posedge aclk);
                src_pause <= 1'b0;
                calm <= 1'b1;
            end
            if (i == 200) begin
                while (pending_q.size() > 0) @(posedge aclk);
                calm <= 1'b0;
            end
        end
        while (pending_q.size() > 0 || s_tvalid) @(posedge aclk);
        while (chars_q.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
